// ===== hdl/lorenz_euler_stepper_defines.svh =====
// ----------------------------------------------------------------------------
// lorenz_euler_stepper_defines.svh
// Assertion macros used by the stepper sequencer (les_seq).
// ----------------------------------------------------------------------------
`ifndef LORENZ_EULER_STEPPER_DEFINES_SVH
`define LORENZ_EULER_STEPPER_DEFINES_SVH
`ifndef ASSERT_OFF
`define LES_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lorenz_euler_stepper: assertion failed");
`define LES_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lorenz_euler_stepper: assertion failed");
`else
`define LES_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define LES_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/les_pkg.sv =====
// ----------------------------------------------------------------------------
// les_pkg
// Types, constants and helpers of the Lorenz Euler stepper.
// ----------------------------------------------------------------------------
package les_pkg;

   localparam int unsigned TRACE_STEPS_DEF   = 50000;
   localparam int unsigned SEGMENT_STEPS_DEF = 10000;

   localparam int unsigned STEP_W     = 16;
   localparam int unsigned SEG_W      = 3;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned COORD_W    = 32;
   localparam int unsigned DT_W       = 24;
   localparam int unsigned Q_FRAC     = 20;
   localparam int unsigned DT_FRAC    = 24;

   localparam logic [SEG_W-1:0] SEG_MAX = '1;

   localparam logic signed [COORD_W-1:0] SIGMA_RST   = 32'sd10485760;
   localparam logic signed [COORD_W-1:0] BETA_RST    = 32'sd2796139;
   localparam logic signed [COORD_W-1:0] RHO_RST     = 32'sd29360128;
   localparam logic        [DT_W-1:0]    DT_RST      = 24'd16777;
   localparam logic signed [COORD_W-1:0] START_RST   = 32'sd1048576;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIGMA,
      CSR_BETA,
      CSR_RHO,
      CSR_TIME_STEP,
      CSR_START_X,
      CSR_START_Y,
      CSR_START_Z
   } les_csr_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_PRE,
      S_RUN,
      S_EMIT
   } les_state_type;

   // destination of a multiplier pass
   typedef enum logic [2:0] {
      DST_DX,
      DST_DY,
      DST_P3,
      DST_DZ,
      DST_NX,
      DST_NY,
      DST_NZ
   } les_dst_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] sigma;
      logic signed [COORD_W-1:0] beta;
      logic signed [COORD_W-1:0] rho;
      logic        [DT_W-1:0]    time_step;
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] start_z;
   } les_cfg_type;

   typedef struct packed {
      logic                      valid;
      logic                      coarse;
      les_dst_type               dst;
      logic signed [COORD_W:0]   a;
      logic signed [COORD_W-1:0] b;
   } les_op_type;

   typedef struct packed {
      logic                      negate;
      logic signed [COORD_W-1:0] addend;
   } les_acc_type;

   typedef struct packed {
      logic                      valid;
      les_dst_type               dst;
      logic signed [COORD_W-1:0] value;
   } les_res_type;

   function automatic logic signed [COORD_W:0] sext33(input logic signed [COORD_W-1:0] v);
      return $signed({v[COORD_W-1], v});
   endfunction

   function automatic logic signed [COORD_W-1:0] sat33(input logic signed [COORD_W:0] v);
      logic signed [COORD_W-1:0] r;
      if (v[COORD_W] != v[COORD_W-1]) begin
         r = v[COORD_W] ? $signed({1'b1, {(COORD_W-1){1'b0}}})
                        : $signed({1'b0, {(COORD_W-1){1'b1}}});
      end else begin
         r = $signed(v[COORD_W-1:0]);
      end
      return r;
   endfunction

endpackage

// ===== hdl/les_ifs.sv =====
// ----------------------------------------------------------------------------
// les_ifs
// Request and response channels of the Lorenz Euler stepper.
// ----------------------------------------------------------------------------
interface les_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface les_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;
   logic [2:0]         segment;
   logic               trace_end;

   modport source (output valid, output point_x, output point_y, output point_z,
                   output segment, output trace_end, input ready);
   modport sink   (input valid, input point_x, input point_y, input point_z,
                   input segment, input trace_end, output ready);
endinterface

// ===== hdl/lorenz_euler_stepper.sv =====
// ----------------------------------------------------------------------------
// lorenz_euler_stepper
// Fixed-point Lorenz attractor tracer, one explicit Euler step per request.
// ----------------------------------------------------------------------------
// Each request transfer advances (x, y, z) by one Euler step and returns the
// new point with its segment index and a trace-end flag; restart reloads the
// start point first. A step computes the differences, then makes seven passes
// through a single shared 33x32 multiplier with product, round/saturate and
// accumulate stages, then writes the result once the output register is free
// and returns to idle for the next handshake. The result sits in an output
// register, so a new request is taken while it waits. Registers are written
// through csr_*; the user must write them only while no step is in flight,
// as the block does not enforce it; unknown indexes are ignored.
module lorenz_euler_stepper import les_pkg::*; #(
   parameter int unsigned TRACE_STEPS   = TRACE_STEPS_DEF,
   parameter int unsigned SEGMENT_STEPS = SEGMENT_STEPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   les_req_if.sink               req_chan,
   les_rsp_if.source             rsp_chan,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   les_cfg_type cfg_ff, cfg_in;
   les_op_type  op;
   les_acc_type acc;
   les_dst_type acc_dst;
   les_res_type res;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_SIGMA:     cfg_in.sigma     = $signed(csr_wdata);
            CSR_BETA:      cfg_in.beta      = $signed(csr_wdata);
            CSR_RHO:       cfg_in.rho       = $signed(csr_wdata);
            CSR_TIME_STEP: cfg_in.time_step = csr_wdata[DT_W-1:0];
            CSR_START_X:   cfg_in.start_x   = $signed(csr_wdata);
            CSR_START_Y:   cfg_in.start_y   = $signed(csr_wdata);
            CSR_START_Z:   cfg_in.start_z   = $signed(csr_wdata);
            default:       cfg_in           = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{sigma: SIGMA_RST, beta: BETA_RST, rho: RHO_RST,
                     time_step: DT_RST, start_x: START_RST,
                     start_y: START_RST, start_z: START_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   les_seq #(
      .TRACE_STEPS   (TRACE_STEPS),
      .SEGMENT_STEPS (SEGMENT_STEPS)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .req     (req_chan),
      .rsp     (rsp_chan),
      .op      (op),
      .acc     (acc),
      .acc_dst (acc_dst),
      .res     (res)
   );

   les_mac_unit u_mac (
      .clock   (clock),
      .reset   (reset),
      .op      (op),
      .acc     (acc),
      .acc_dst (acc_dst),
      .res     (res)
   );

endmodule

// ===== hdl/les_mac_unit.sv =====
// ----------------------------------------------------------------------------
// les_mac_unit
// Shared 33x32 multiplier with round, saturate and accumulate stages.
// ----------------------------------------------------------------------------
module les_mac_unit import les_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  les_op_type  op,
   input  les_acc_type acc,
   output les_dst_type acc_dst,
   output les_res_type res
);

   localparam logic signed [63:0] RND_FINE   = 64'sd1 <<< (Q_FRAC - 1);
   localparam logic signed [63:0] RND_COARSE = 64'sd1 <<< (DT_FRAC - 1);
   localparam logic signed [63:0] SAT_HI     = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] SAT_LO     = 64'shFFFF_FFFF_8000_0000;

   logic                      p_valid_ff;
   logic                      p_coarse_ff;
   les_dst_type               p_dst_ff;
   logic signed [63:0]        prod_ff;
   logic signed [63:0]        prod_in;
   logic signed [64:0]        full;

   logic                      q_valid_ff;
   les_dst_type               q_dst_ff;
   logic signed [COORD_W-1:0] q_ff;
   logic signed [COORD_W-1:0] q_in;
   logic signed [63:0]        rounded;
   logic signed [63:0]        shifted;

   logic signed [COORD_W:0]   sum;

   assign full    = op.a * op.b;
   assign prod_in = $signed(full[63:0]);

   always_comb begin
      rounded = prod_ff + (p_coarse_ff ? RND_COARSE : RND_FINE);
      shifted = p_coarse_ff ? (rounded >>> DT_FRAC) : (rounded >>> Q_FRAC);
      if (shifted > SAT_HI) begin
         q_in = SAT_HI[COORD_W-1:0];
      end else if (shifted < SAT_LO) begin
         q_in = SAT_LO[COORD_W-1:0];
      end else begin
         q_in = $signed(shifted[COORD_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         q_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= op.valid;
         q_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p_coarse_ff <= op.coarse;
      p_dst_ff    <= op.dst;
      prod_ff     <= prod_in;
      q_dst_ff    <= p_dst_ff;
      q_ff        <= q_in;
   end

   // negate: product minus addend
   always_comb begin
      sum = acc.negate ? (sext33(q_ff) - sext33(acc.addend))
                       : (sext33(acc.addend) + sext33(q_ff));
   end

   assign acc_dst   = q_dst_ff;
   assign res.valid = q_valid_ff;
   assign res.dst   = q_dst_ff;
   assign res.value = sat33(sum);

endmodule

// ===== hdl/les_seq.sv =====
// ----------------------------------------------------------------------------
// les_seq
// Step sequencer: operand selection, working registers, counters, output.
// ----------------------------------------------------------------------------
`include "lorenz_euler_stepper_defines.svh"

module les_seq import les_pkg::*; #(
   parameter int unsigned TRACE_STEPS   = TRACE_STEPS_DEF,
   parameter int unsigned SEGMENT_STEPS = SEGMENT_STEPS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  les_cfg_type    cfg,
   les_req_if.sink        req,
   les_rsp_if.source      rsp,
   output les_op_type     op,
   output les_acc_type    acc,
   input  les_dst_type    acc_dst,
   input  les_res_type    res
);

   localparam logic [STEP_W-1:0] LAST_IDX = STEP_W'(TRACE_STEPS - 1);
   localparam logic [STEP_W-1:0] SEG_LAST = STEP_W'(SEGMENT_STEPS - 1);

   // issue slots of the run phase
   localparam logic [3:0] SLOT_DX   = 4'd1;
   localparam logic [3:0] SLOT_DY   = 4'd2;
   localparam logic [3:0] SLOT_P3   = 4'd3;
   localparam logic [3:0] SLOT_DZ   = 4'd4;
   localparam logic [3:0] SLOT_NX   = 4'd5;
   localparam logic [3:0] SLOT_NY   = 4'd6;
   localparam logic [3:0] SLOT_NZ   = 4'd7;
   localparam logic [3:0] SLOT_DONE = 4'd9;

   les_state_type             state_ff, state_in;
   logic [3:0]                cnt_ff, cnt_in;
   logic signed [COORD_W-1:0] pos_x_ff, pos_x_in;
   logic signed [COORD_W-1:0] pos_y_ff, pos_y_in;
   logic signed [COORD_W-1:0] pos_z_ff, pos_z_in;
   logic signed [COORD_W-1:0] d1_ff, d1_in;
   logic signed [COORD_W-1:0] d2_ff, d2_in;
   logic signed [COORD_W-1:0] dx_ff, dx_in;
   logic signed [COORD_W-1:0] dy_ff, dy_in;
   logic signed [COORD_W-1:0] dz_ff, dz_in;
   logic signed [COORD_W-1:0] p3_ff, p3_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [STEP_W-1:0]         seg_pos_ff, seg_pos_in;
   logic [SEG_W-1:0]          seg_idx_ff, seg_idx_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_W-1:0] out_x_ff, out_x_in;
   logic signed [COORD_W-1:0] out_y_ff, out_y_in;
   logic signed [COORD_W-1:0] out_z_ff, out_z_in;
   logic [SEG_W-1:0]          out_seg_ff, out_seg_in;
   logic                      out_end_ff, out_end_in;

   logic accept;
   logic last;
   logic rsp_free;

   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   assign last      = (step_ff >= LAST_IDX);
   assign rsp_free  = !rsp_valid_ff || rsp.ready;

   always_comb begin
      case (acc_dst)
         DST_DY:  acc = '{negate: 1'b1, addend: pos_y_ff};
         DST_DZ:  acc = '{negate: 1'b1, addend: p3_ff};
         DST_NX:  acc = '{negate: 1'b0, addend: pos_x_ff};
         DST_NY:  acc = '{negate: 1'b0, addend: pos_y_ff};
         DST_NZ:  acc = '{negate: 1'b0, addend: pos_z_ff};
         default: acc = '{negate: 1'b0, addend: '0};
      endcase
   end

   always_comb begin
      op = '{valid: 1'b0, coarse: 1'b0, dst: DST_DX, a: '0, b: '0};
      if (state_ff == S_RUN) begin
         case (cnt_ff)
            SLOT_DX: op = '{1'b1, 1'b0, DST_DX, sext33(cfg.sigma), d1_ff};
            SLOT_DY: op = '{1'b1, 1'b0, DST_DY, sext33(pos_x_ff), d2_ff};
            SLOT_P3: op = '{1'b1, 1'b0, DST_P3, sext33(cfg.beta), pos_z_ff};
            SLOT_DZ: op = '{1'b1, 1'b0, DST_DZ, sext33(pos_x_ff), pos_y_ff};
            SLOT_NX: op = '{1'b1, 1'b1, DST_NX, $signed({9'd0, cfg.time_step}), dx_ff};
            SLOT_NY: op = '{1'b1, 1'b1, DST_NY, $signed({9'd0, cfg.time_step}), dy_ff};
            SLOT_NZ: op = '{1'b1, 1'b1, DST_NZ, $signed({9'd0, cfg.time_step}), dz_ff};
            default: op.valid = 1'b0;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      pos_z_in     = pos_z_ff;
      d1_in        = d1_ff;
      d2_in        = d2_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      dz_in        = dz_ff;
      p3_in        = p3_ff;
      step_in      = step_ff;
      seg_pos_in   = seg_pos_ff;
      seg_idx_in   = seg_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_z_in     = out_z_ff;
      out_seg_in   = out_seg_ff;
      out_end_in   = out_end_ff;

      if (res.valid) begin
         case (res.dst)
            DST_DX:  dx_in    = res.value;
            DST_DY:  dy_in    = res.value;
            DST_P3:  p3_in    = res.value;
            DST_DZ:  dz_in    = res.value;
            DST_NX:  pos_x_in = res.value;
            DST_NY:  pos_y_in = res.value;
            DST_NZ:  pos_z_in = res.value;
            default: dx_in    = dx_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req.restart) begin
                  pos_x_in   = cfg.start_x;
                  pos_y_in   = cfg.start_y;
                  pos_z_in   = cfg.start_z;
                  step_in    = '0;
                  seg_pos_in = '0;
                  seg_idx_in = '0;
               end
               state_in = S_PRE;
            end
         end
         S_PRE: begin
            d1_in    = sat33(sext33(pos_y_ff) - sext33(pos_x_ff));
            d2_in    = sat33(sext33(cfg.rho) - sext33(pos_z_ff));
            cnt_in   = SLOT_DX;
            state_in = S_RUN;
         end
         S_RUN: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == SLOT_DONE) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               out_x_in     = pos_x_ff;
               out_y_in     = pos_y_ff;
               out_z_in     = pos_z_ff;
               out_seg_in   = seg_idx_ff;
               out_end_in   = last;
               if (last) begin
                  pos_x_in   = cfg.start_x;
                  pos_y_in   = cfg.start_y;
                  pos_z_in   = cfg.start_z;
                  step_in    = '0;
                  seg_pos_in = '0;
                  seg_idx_in = '0;
               end else begin
                  step_in = step_ff + 1'b1;
                  if (seg_pos_ff == SEG_LAST) begin
                     seg_pos_in = '0;
                     if (seg_idx_ff != SEG_MAX) begin
                        seg_idx_in = seg_idx_ff + 1'b1;
                     end
                  end else begin
                     seg_pos_in = seg_pos_ff + 1'b1;
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         pos_x_ff     <= START_RST;
         pos_y_ff     <= START_RST;
         pos_z_ff     <= START_RST;
         step_ff      <= '0;
         seg_pos_ff   <= '0;
         seg_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         pos_z_ff     <= pos_z_in;
         step_ff      <= step_in;
         seg_pos_ff   <= seg_pos_in;
         seg_idx_ff   <= seg_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      d1_ff      <= d1_in;
      d2_ff      <= d2_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      dz_ff      <= dz_in;
      p3_ff      <= p3_in;
      out_x_ff   <= out_x_in;
      out_y_ff   <= out_y_in;
      out_z_ff   <= out_z_in;
      out_seg_ff <= out_seg_in;
      out_end_ff <= out_end_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.point_x   = out_x_ff;
   assign rsp.point_y   = out_y_ff;
   assign rsp.point_z   = out_z_ff;
   assign rsp.segment   = out_seg_ff;
   assign rsp.trace_end = out_end_ff;

   `LES_ASSERT_IMP(a_issue_in_run, clock, reset, op.valid, state_ff == S_RUN)
   `LES_ASSERT_IMP(a_result_in_run, clock, reset, res.valid, state_ff == S_RUN)
   `LES_ASSERT_NXT(a_busy_after_accept, clock, reset, req.valid && req.ready, !req.ready)
   `LES_ASSERT_IMP(a_rsp_from_emit, clock, reset, $rose(rsp.valid), $past(state_ff) == S_EMIT)

endmodule

// ===== tb/tb_lorenz_euler_stepper.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lorenz_euler_stepper
// Checks every point of the fixed-point Lorenz Euler stepper against a local
// prediction of the trace: reset defaults, saturation at the extremes, timing
// of register updates, ignored register indexes, randomized coefficients with
// idle and stall patterns on both channels, and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_lorenz_euler_stepper;
   import les_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED   = 3'd7;
   localparam longint               RUN_LIMIT_NS = 4_000_000;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [SEG_W-1:0]          seg;
      logic                      last;
   } trace_point_t;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   les_req_if req_if ();
   les_rsp_if rsp_if ();

   lorenz_euler_stepper DUT (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_if),
      .rsp_chan     (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // local copy of the coefficients and the trace state
   les_cfg_type               coef;
   logic signed [COORD_W-1:0] trace_x, trace_y, trace_z;
   logic [STEP_W-1:0]         trace_count;

   trace_point_t expected_points[$];
   int           error_count     = 0;
   int           sender_idle_pct = 0;
   int           rx_stall_pct    = 0;
   int           rx_hold_cycles  = 0;

   always #5 clock = ~clock;

   function automatic logic signed [COORD_W-1:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[COORD_W-1:0];
   endfunction

   // Q12.20 product, rounded half up
   function automatic logic signed [COORD_W-1:0] fx_mul(input logic signed [COORD_W-1:0] a,
                                                        input logic signed [COORD_W-1:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return clamp32((p + 64'sd524288) >>> Q_FRAC);
   endfunction

   function automatic logic signed [COORD_W-1:0] fx_advance(input logic signed [COORD_W-1:0] c,
                                                            input logic signed [COORD_W-1:0] d);
      longint p;
      p = longint'(coef.time_step) * longint'(d);
      return clamp32(longint'(c) + ((p + 64'sd8388608) >>> DT_FRAC));
   endfunction

   task automatic reload_trace();
      trace_x     = coef.start_x;
      trace_y     = coef.start_y;
      trace_z     = coef.start_z;
      trace_count = '0;
   endtask

   task automatic lorenz_step(input logic restart_bit, output trace_point_t pt);
      logic signed [COORD_W-1:0] dx, dy, dz;
      int unsigned               quot;
      if (restart_bit) reload_trace();
      dx = fx_mul(coef.sigma, clamp32(longint'(trace_y) - longint'(trace_x)));
      dy = clamp32(longint'(fx_mul(trace_x, clamp32(longint'(coef.rho) - longint'(trace_z))))
                   - longint'(trace_y));
      dz = clamp32(longint'(fx_mul(trace_x, trace_y)) - longint'(fx_mul(coef.beta, trace_z)));
      pt.x = fx_advance(trace_x, dx);
      pt.y = fx_advance(trace_y, dy);
      pt.z = fx_advance(trace_z, dz);
      quot = trace_count / SEGMENT_STEPS_DEF;
      pt.seg  = (quot > SEG_MAX) ? SEG_MAX : quot[SEG_W-1:0];
      pt.last = (int'(trace_count) + 1) >= TRACE_STEPS_DEF;
      trace_x = pt.x;
      trace_y = pt.y;
      trace_z = pt.z;
      if (pt.last) reload_trace();
      else trace_count = trace_count + 1'b1;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < 100)
         $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin : check_points
      trace_point_t want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_points.size() == 0) begin
            report_mismatch("unexpected point", rsp_if.point_x, 32'd0);
         end else begin
            want = expected_points.pop_front();
            if (rsp_if.point_x !== want.x) report_mismatch("point_x", rsp_if.point_x, want.x);
            if (rsp_if.point_y !== want.y) report_mismatch("point_y", rsp_if.point_y, want.y);
            if (rsp_if.point_z !== want.z) report_mismatch("point_z", rsp_if.point_z, want.z);
            if (rsp_if.segment !== want.seg)
               report_mismatch("segment", rsp_if.segment, want.seg);
            if (rsp_if.trace_end !== want.last)
               report_mismatch("trace_end", rsp_if.trace_end, want.last);
         end
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (rx_hold_cycles > 0) begin
         rsp_if.ready   <= 1'b0;
         rx_hold_cycles <= rx_hold_cycles - 1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      case (idx)
         CSR_SIGMA:     coef.sigma     = data;
         CSR_BETA:      coef.beta      = data;
         CSR_RHO:       coef.rho       = data;
         CSR_TIME_STEP: coef.time_step = data[DT_W-1:0];
         CSR_START_X:   coef.start_x   = data;
         CSR_START_Y:   coef.start_y   = data;
         CSR_START_Z:   coef.start_z   = data;
         default: ;
      endcase
   endtask

   task automatic write_config(input logic [31:0] sigma, input logic [31:0] beta,
                               input logic [31:0] rho, input logic [31:0] dt,
                               input logic [31:0] sx, input logic [31:0] sy,
                               input logic [31:0] sz);
      write_reg(CSR_SIGMA, sigma);
      write_reg(CSR_BETA, beta);
      write_reg(CSR_RHO, rho);
      write_reg(CSR_TIME_STEP, dt);
      write_reg(CSR_START_X, sx);
      write_reg(CSR_START_Y, sy);
      write_reg(CSR_START_Z, sz);
      csr_write_en <= 1'b0;
   endtask

   task automatic send_step(input logic restart_bit);
      trace_point_t pt;
      req_if.valid   <= 1'b1;
      req_if.restart <= restart_bit;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      lorenz_step(restart_bit, pt);
      expected_points.push_back(pt);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid   <= 1'b0;
         req_if.restart <= 1'($urandom_range(1));
         @(posedge clock);
      end
   endtask

   // stop offering and let every outstanding point come back
   task automatic finish_phase();
      req_if.valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic test_reset_defaults();
      repeat (4) send_step(1'b0);
      send_step(1'b1);
      repeat (2) send_step(1'b0);
      finish_phase();
   endtask

   task automatic test_saturation();
      write_config(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF,
                   32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
      send_step(1'b1);
      repeat (2) send_step(1'b0);
      finish_phase();
      write_config(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h00000000,
                   32'h80000000, 32'h7FFFFFFF, 32'h80000000);
      send_step(1'b1);
      send_step(1'b0);
      finish_phase();
   endtask

   // coefficients act on the next step, start point only on a reload
   task automatic test_register_timing();
      write_config(SIGMA_RST, BETA_RST, RHO_RST, 32'd1048576, START_RST, START_RST, START_RST);
      send_step(1'b1);
      send_step(1'b0);
      finish_phase();
      write_reg(CSR_START_X, 32'hFFE00000);
      write_reg(CSR_START_Y, 32'h00300000);
      write_reg(CSR_START_Z, 32'h01000000);
      write_reg(CSR_SIGMA, 32'h00200000);
      csr_write_en <= 1'b0;
      repeat (2) send_step(1'b0);
      send_step(1'b1);
      finish_phase();
   endtask

   task automatic test_unknown_index();
      write_reg(CSR_UNUSED, $urandom);
      write_reg(CSR_UNUSED, 32'hFFFFFFFF);
      csr_write_en <= 1'b0;
      repeat (2) send_step(1'b0);
      finish_phase();
   endtask

   task automatic pick_config();
      if ($urandom_range(1) == 0) begin
         write_config(int'(SIGMA_RST) + int'($urandom_range(8388608)) - 4194304,
                      int'(BETA_RST) + int'($urandom_range(2097152)) - 1048576,
                      int'(RHO_RST) + int'($urandom_range(16777216)) - 8388608,
                      $urandom_range(65535),
                      int'($urandom_range(67108864)) - 33554432,
                      int'($urandom_range(67108864)) - 33554432,
                      int'($urandom_range(67108864)) - 33554432);
      end else begin
         write_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   task automatic test_random_trace();
      int idle_tbl[4]  = '{0, 83, 0, 33};
      int stall_tbl[4] = '{0, 0, 83, 33};
      for (int p = 0; p < 4; p++) begin
         sender_idle_pct = idle_tbl[p];
         rx_stall_pct    = stall_tbl[p];
         for (int c = 0; c < 2; c++) begin
            pick_config();
            send_step(1'b1);
            repeat (199) send_step($urandom_range(31) == 0);
            finish_phase();
         end
      end
      sender_idle_pct = 0;
      rx_stall_pct    = 0;
   endtask

   // receiver holds off while items keep coming, input must back up
   task automatic test_output_holdoff();
      rx_hold_cycles = 300;
      repeat (24) send_step($urandom_range(7) == 0);
      finish_phase();
   endtask

   initial begin
      coef = '{sigma: SIGMA_RST, beta: BETA_RST, rho: RHO_RST, time_step: DT_RST,
               start_x: START_RST, start_y: START_RST, start_z: START_RST};
      reload_trace();
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.restart = 1'b0;
      csr_write_en   = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_saturation();
      test_register_timing();
      test_unknown_index();
      test_random_trace();
      test_output_holdoff();

      repeat (24) @(posedge clock);
      if (error_count == 0 && expected_points.size() == 0) begin
         $display("tb_lorenz_euler_stepper: PASS");
      end else begin
         $display("tb_lorenz_euler_stepper: FAIL");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("tb_lorenz_euler_stepper: FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/les_pkg.sv
hdl/les_ifs.sv
hdl/les_mac_unit.sv
hdl/les_seq.sv
hdl/lorenz_euler_stepper.sv
tb/tb_lorenz_euler_stepper.sv
